// File: rtl/infix_expression_evaluator_assert.svh
// Assertion macros used by the infix expression evaluator RTL.
// Each macro takes a label, clock, active-low reset, condition(s) and a message string.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define IEE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IEE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/iee_pkg.sv
// Package for the infix expression evaluator: character codes, item kinds,
// queue entry and control structs. No dependencies.
`default_nettype none

package iee_pkg;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QAW     = 2;

  // Classified character; K_FIN is an internal action for the final close.
  typedef enum logic [2:0] {
    K_NONE,
    K_DIGIT,
    K_MUL,
    K_DIV,
    K_ADD,
    K_SUB,
    K_FIN
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } termop_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } item_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic dz;
  } md_rsp_t;

endpackage

`default_nettype wire

// File: rtl/iee_front.sv
// Front end: takes input character transactions and classifies them into queue items.
// Depends on iee_pkg.
`default_nettype none

module iee_front (
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] ch
  input  wire logic          in_tlast,
  output logic               q_valid,
  input  wire logic          q_ready,
  output iee_pkg::item_t     q_item
);
  import iee_pkg::*;

  kind_t      kind;
  logic [3:0] digit;

  always_comb begin
    kind  = K_NONE;
    digit = 4'(in_tdata - CH_0);
    if (in_tdata inside {[CH_0:CH_9]}) begin
      kind = K_DIGIT;
    end else begin
      case (in_tdata)
        CH_PLUS:  kind = K_ADD;
        CH_MINUS: kind = K_SUB;
        CH_STAR:  kind = K_MUL;
        CH_SLASH: kind = K_DIV;
        CH_SPACE: kind = K_NONE;
        default:  kind = K_NONE;  // unknown bytes act as spaces
      endcase
    end
  end

  assign q_valid       = in_tvalid;
  assign in_tready     = q_ready;
  assign q_item.kind   = kind;
  assign q_item.digit  = digit;
  assign q_item.last   = in_tlast;

endmodule

`default_nettype wire

// File: rtl/iee_fifo.sv
// Small register queue between front and back ends.
// Depends on iee_pkg.
`default_nettype none

module iee_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire iee_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output iee_pkg::item_t      pop_item
);
  import iee_pkg::*;

  item_t            mem_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != (QAW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/iee_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring signed divide,
// one bit per cycle. Depends on iee_pkg.
`default_nettype none

module iee_muldiv #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iee_pkg::md_req_t      req,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output iee_pkg::md_rsp_t           rsp,
  output logic [DATA_WIDTH-1:0]      res
);
  import iee_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  dz_r, dz_nxt;
  logic                  is_div_r, is_div_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   r_sh, diff;

  always_comb begin
    mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    r_sh  = {acc_r, x_r[DATA_WIDTH-1]};
    diff  = r_sh - {1'b0, y_r};

    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    dz_nxt     = dz_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;

    if (req.start) begin
      is_div_nxt = req.is_div;
      dz_nxt     = 1'b0;
      acc_nxt    = '0;
      cnt_nxt    = CW'(DATA_WIDTH - 1);
      if (req.is_div) begin
        x_nxt   = mag_a;
        y_nxt   = mag_b;
        neg_nxt = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        if (mag_b == '0) begin
          dz_nxt   = 1'b1;
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
        end
      end else begin
        x_nxt    = a;
        y_nxt    = b;
        neg_nxt  = 1'b0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (is_div_r) begin
        if (!diff[DATA_WIDTH]) begin
          acc_nxt = diff[DATA_WIDTH-1:0];
        end else begin
          acc_nxt = r_sh[DATA_WIDTH-1:0];
        end
        x_nxt = {x_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt = {x_r[DATA_WIDTH-2:0], 1'b0};
        y_nxt = {1'b0, y_r[DATA_WIDTH-1:1]};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dz_r     <= dz_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.dz   = dz_r;
  assign res      = is_div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : acc_r;

endmodule

`default_nettype wire

// File: rtl/iee_back.sv
// Back end: precedence state machine with sum/term/number accumulators and
// the result register. Depends on iee_pkg, iee_muldiv and the assertion macros.
`default_nettype none
`include "infix_expression_evaluator_assert.svh"

module iee_back #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire iee_pkg::item_t q_item,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [31:0]         out_value,
  output logic                out_dz
);
  import iee_pkg::*;

  bk_state_t             state_r, state_nxt;
  logic [DATA_WIDTH-1:0] sum_r, sum_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] term_r, term_nxt;
  termop_t               op_r, op_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic                  err_r, err_nxt;
  kind_t                 act_r, act_nxt;
  logic                  fin_r, fin_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic                  out_dz_r, out_dz_nxt;

  md_req_t               md_req;
  md_rsp_t               md_rsp;
  logic [DATA_WIDTH-1:0] md_res;

  logic                  pop, is_op, needs_md, emit;
  logic                  apply_en, apply_dz;
  kind_t                 apply_kind;
  logic [DATA_WIDTH-1:0] apply_t, sum_upd;
  logic                  err_fin;

  iee_muldiv #(.DATA_WIDTH(DATA_WIDTH)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (term_r),
    .b     (num_r),
    .rsp   (md_rsp),
    .res   (md_res)
  );

  // a closing last item is only taken when the result register is free
  assign pop = (state_r == BK_IDLE) && q_valid && (!q_item.last || !out_valid_r);
  assign q_ready  = (state_r == BK_IDLE) && (!q_item.last || !out_valid_r);
  assign is_op    = (q_item.kind == K_MUL) || (q_item.kind == K_DIV) ||
                    (q_item.kind == K_ADD) || (q_item.kind == K_SUB);
  assign needs_md = (op_r == OP_MUL) || (op_r == OP_DIV);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          if (is_op && needs_md) begin
            state_nxt = BK_CALC;
          end else if (q_item.last) begin
            state_nxt = BK_FIN;
          end
        end
      end
      BK_FIN: begin
        state_nxt = needs_md ? BK_CALC : BK_IDLE;
      end
      BK_CALC: begin
        if (md_rsp.done) begin
          if (act_r == K_FIN) begin
            state_nxt = BK_IDLE;
          end else if (fin_r) begin
            state_nxt = BK_FIN;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    md_req.start  = 1'b0;
    md_req.is_div = (op_r == OP_DIV);
    apply_en      = 1'b0;
    apply_kind    = K_NONE;
    apply_t       = num_r;
    apply_dz      = 1'b0;
    act_nxt       = act_r;
    fin_nxt       = fin_r;

    sum_nxt  = sum_r;
    neg_nxt  = neg_r;
    term_nxt = term_r;
    op_nxt   = op_r;
    num_nxt  = num_r;
    err_nxt  = err_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;

    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          fin_nxt = q_item.last;
          if (is_op) begin
            if (needs_md) begin
              md_req.start = 1'b1;
              act_nxt      = q_item.kind;
            end else begin
              apply_en   = 1'b1;
              apply_kind = q_item.kind;
            end
          end else if (q_item.kind == K_DIGIT) begin
            num_nxt = (num_r << 3) + (num_r << 1) + DATA_WIDTH'(q_item.digit);
          end
        end
      end
      BK_FIN: begin
        if (needs_md) begin
          md_req.start = 1'b1;
          act_nxt      = K_FIN;
        end else begin
          apply_en   = 1'b1;
          apply_kind = K_FIN;
        end
      end
      BK_CALC: begin
        if (md_rsp.done) begin
          apply_en   = 1'b1;
          apply_kind = act_r;
          apply_dz   = md_rsp.dz;
          apply_t    = md_rsp.dz ? '0 : md_res;
        end
      end
      default: ;
    endcase

    sum_upd = neg_r ? (sum_r - apply_t) : (sum_r + apply_t);
    err_fin = err_r | apply_dz;
    emit    = apply_en && (apply_kind == K_FIN);

    if (apply_en) begin
      err_nxt = err_fin;
      num_nxt = '0;
      case (apply_kind)
        K_MUL: begin
          term_nxt = apply_t;
          op_nxt   = OP_MUL;
        end
        K_DIV: begin
          term_nxt = apply_t;
          op_nxt   = OP_DIV;
        end
        K_ADD, K_SUB: begin
          sum_nxt  = sum_upd;
          op_nxt   = OP_NONE;
          term_nxt = '0;
          neg_nxt  = (apply_kind == K_SUB);
        end
        K_FIN: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = err_fin ? 32'd0 : 32'($signed(sum_upd));
          out_dz_nxt    = err_fin;
          sum_nxt       = '0;
          neg_nxt       = 1'b0;
          term_nxt      = '0;
          op_nxt        = OP_NONE;
          err_nxt       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sum_r       <= '0;
      neg_r       <= 1'b0;
      term_r      <= '0;
      op_r        <= OP_NONE;
      num_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      neg_r       <= neg_nxt;
      term_r      <= term_nxt;
      op_r        <= op_nxt;
      num_r       <= num_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    fin_r       <= fin_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_dz     = out_dz_r;

  `IEE_ASSERT_IMP(a_last_pop_free, clk, rst_n, pop && q_item.last, !out_valid_r, "last item taken while result pending")
  `IEE_ASSERT_IMP(a_calc_unit_live, clk, rst_n, state_r == BK_CALC, md_rsp.busy || md_rsp.done, "waiting on an idle mul/div unit")
  `IEE_ASSERT_IMP(a_done_in_calc, clk, rst_n, md_rsp.done, state_r == BK_CALC, "mul/div result with no one waiting")
  `IEE_ASSERT_NXT(a_emit_clears, clk, rst_n, emit, (sum_r == '0) && (op_r == OP_NONE) && !err_r && out_valid_r, "state not cleared after result")

endmodule

`default_nettype wire

// File: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: front end, item queue and back end.
// Depends on iee_pkg, iee_front, iee_fifo, iee_back (which holds iee_muldiv).
`default_nettype none

// Evaluates an integer expression sent one ASCII character per input transaction
// (digits, + - * /, anything else ignored like a space; tlast marks the last
// character) and returns one output transaction per expression: the value in
// tdata, wrapped to DATA_WIDTH bits and sign-extended or truncated to 32, and a
// divide-by-zero flag in tuser (value reads 0 when it is set). * and / bind tighter
// than + and -, equal precedence goes left to right, division truncates toward zero.
// Timing: the front end classifies a character per cycle into a 4-entry queue while the
// queue has room. The back end handles a digit, a space or an operator that closes a plain
// term as it pops it; an operator or end of expression that closes a pending * or / term
// runs the shared bit-serial multiply/divide unit; the last character adds a final close
// step. The result register lets the next expression start while a result waits, but a
// second last character waits until it is taken.
module infix_expression_evaluator #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] ch
  input  wire logic        in_tlast,    // last character of the expression
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] value (signed)
  output logic             out_tuser    // [0] div_zero
);
  import iee_pkg::*;

  item_t front_item, back_item;
  logic  front_valid, front_ready;
  logic  back_valid, back_ready;

  // classify characters
  iee_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (front_valid),
    .q_ready   (front_ready),
    .q_item    (front_item)
  );

  // decouples intake from multi-cycle evaluation
  iee_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  // precedence evaluation and result register
  iee_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (back_valid),
    .q_ready    (back_ready),
    .q_item     (back_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_dz     (out_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/infix_expression_evaluator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for infix_expression_evaluator: directed and random expressions,
// checked against an in-bench evaluator with precedence, wraparound and divide-by-zero.
// Depends on iee_pkg and the infix_expression_evaluator RTL.

module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 120;    // well past one multiply/divide pass plus the final close
  localparam int ITEM_TARGET  = 1100;   // digits, operators and last characters, not other ignored bytes
  localparam int STEADY_ITEMS = 300;    // end of the stretch run with no idling

  typedef struct {
    logic [31:0] value;
    logic        div_zero;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // Idling is switched off on both sides while this is set.
  logic        steady = 1'b0;

  int          mismatches = 0;
  int          results_seen = 0;
  int          counted_items = 0;
  int          cycle_count = 0;

  result_t     expected_results[$];
  logic [7:0]  expr_chars[$];

  string big_numbers[5] = '{"2147483647", "2147483648", "4294967295", "4294967296",
                            "99999999999"};

  // Evaluator state, mirrors the block between characters.
  logic [31:0] run_sum = '0;
  logic        sub_next = 1'b0;
  logic [31:0] term_val = '0;
  termop_t     term_kind = OP_NONE;
  logic [31:0] num_val = '0;
  logic        saw_div0 = 1'b0;

  infix_expression_evaluator #(
    .DATA_WIDTH(32)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- evaluator

  // Signed quotient truncated toward zero; a zero divisor flags the expression.
  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == '0) begin
      saw_div0 = 1'b1;
      return '0;
    end
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Finish the pending term with the number built so far.
  function automatic logic [31:0] close_term();
    logic [31:0] t;
    case (term_kind)
      OP_MUL: t = term_val * num_val;
      OP_DIV: t = quotient(term_val, num_val);
      default: t = num_val;
    endcase
    num_val = '0;
    return t;
  endfunction

  function automatic void add_term(logic [31:0] t);
    run_sum = sub_next ? run_sum - t : run_sum + t;
  endfunction

  // Apply one accepted character; on the last one, queue the expected result.
  function automatic void evaluate_char(logic [7:0] c, logic fin);
    result_t r;
    if (c >= CH_0 && c <= CH_9) begin
      num_val = num_val * 32'd10 + (c - CH_0);
    end else if (c == CH_STAR || c == CH_SLASH) begin
      term_val  = close_term();
      term_kind = (c == CH_STAR) ? OP_MUL : OP_DIV;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      add_term(close_term());
      term_kind = OP_NONE;
      term_val  = '0;
      sub_next  = (c == CH_MINUS);
    end
    if (fin) begin
      add_term(close_term());
      r.value    = saw_div0 ? '0 : run_sum;
      r.div_zero = saw_div0;
      expected_results.push_back(r);
      run_sum   = '0;
      sub_next  = 1'b0;
      term_val  = '0;
      term_kind = OP_NONE;
      num_val   = '0;
      saw_div0  = 1'b0;
    end
  endfunction

  function automatic bit is_significant(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s, got %h, want %h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Receiver side: random stalls on tready, compare every output transaction.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.value)
          report_mismatch("value", out_tdata, want.value);
        if (out_tuser !== want.div_zero)
          report_mismatch("div_zero", {31'b0, out_tuser}, {31'b0, want.div_zero});
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // One input transaction. tvalid stays high from one character to the next
  // unless an idle cycle is drawn, so it is never dropped and raised in one step.
  task automatic send_char(logic [7:0] c, logic fin);
    while (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    evaluate_char(c, fin);
    if (is_significant(c) || fin)
      counted_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++)
      expr_chars.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Byte the block ignores: mostly a space, sometimes any other byte that is no digit or operator.
  function automatic logic [7:0] pick_filler();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(1) == 0 || is_significant(b))
      b = CH_SPACE;
    return b;
  endfunction

  // Zeros often (divisor of zero), short numbers mostly, a few that wrap.
  task automatic push_number();
    int r;
    int digits;
    r = $urandom_range(99);
    if (r < 12) begin
      expr_chars.push_back(CH_0);
    end else if (r < 20) begin
      push_text(big_numbers[$urandom_range(4)]);
    end else begin
      digits = (r < 80) ? $urandom_range(1, 3) : $urandom_range(4, 10);
      repeat (digits) expr_chars.push_back(CH_0 + 8'($urandom_range(9)));
    end
  endtask

  // Mostly well-formed expressions; some raw noise, missing operands,
  // stray bytes inside numbers and trailing operators.
  task automatic build_expression();
    int n_terms;
    logic [7:0] b;
    expr_chars.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom_range(255));
        expr_chars.push_back(b);
      end
      return;
    end
    if ($urandom_range(99) < 10)
      expr_chars.push_back(pick_operator());
    n_terms = $urandom_range(1, 6);
    for (int i = 0; i < n_terms; i++) begin
      if (i > 0)
        expr_chars.push_back(pick_operator());
      if ($urandom_range(99) < 15)
        expr_chars.push_back(pick_filler());
      if ($urandom_range(99) >= 5)
        push_number();
      if ($urandom_range(99) < 8) begin
        expr_chars.push_back(pick_filler());
        if ($urandom_range(1) == 1)
          push_number();   // digits on both sides of the filler join up
      end
    end
    if ($urandom_range(99) < 8)
      expr_chars.push_back(pick_operator());
  endtask

  task automatic send_expression();
    build_expression();
    foreach (expr_chars[i])
      send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_precedence();
    send_text("7-2*3");     // * before -
    send_text("9/ 2+1");    // left to right, space skipped
  endtask

  task automatic test_broken_input();
    send_text("-8/0");      // leading sign, zero divisor
    send_char(8'h31, 1'b0); // stray top byte inside a number, operator last
    send_char(8'hFF, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(CH_STAR, 1'b1);
    send_char(8'h00, 1'b1); // expression of one ignored byte
  endtask

  task automatic test_wraparound();
    send_text("2147483648/4294967295");   // most negative value over -1
    send_text("99999999999*65536+2147483647");
  endtask

  task automatic test_back_to_back();
    steady <= 1'b1;
    while (counted_items < STEADY_ITEMS)
      send_expression();
    steady <= 1'b0;
  endtask

  task automatic test_random_expressions();
    while (counted_items < ITEM_TARGET)
      send_expression();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_precedence();
    test_broken_input();
    test_wraparound();
    test_back_to_back();
    test_random_expressions();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: infix_expression_evaluator.f
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_fifo.sv
rtl/iee_muldiv.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_test.sv
